FILE: design/cpu_exu_pkg.sv
package cpu_exu_pkg;

	localparam int DATA_BITS    = 32;
	localparam int IDX_BITS     = 6;
	localparam int OP_BITS      = 5;
	localparam int NIB_BITS     = 4;
	localparam int REG_COUNT_DEF = 64;
	localparam int IN_TDATA_W   = 96;
	localparam int OUT_TDATA_W  = 72;

	localparam logic [IDX_BITS-1:0] PC_ALIAS = 6'd41;

	typedef enum logic [OP_BITS-1:0] {
		OP_LD8_IMM  = 5'd0,
		OP_LD8_FW   = 5'd1,
		OP_LD16_IMM = 5'd2,
		OP_LD16_FW  = 5'd3,
		OP_LD32     = 5'd4,
		OP_MOVE     = 5'd5,
		OP_ADD_IMM  = 5'd6,
		OP_ADD_REG  = 5'd7,
		OP_SUB_IMM  = 5'd8,
		OP_SUB_REG  = 5'd9,
		OP_EQ_IMM   = 5'd10,
		OP_EQ_REG   = 5'd11,
		OP_JMP_IMM  = 5'd12,
		OP_JMP_REG  = 5'd13,
		OP_JNZ_IMM  = 5'd14,
		OP_JNZ_REG  = 5'd15,
		OP_JZ_IMM   = 5'd16,
		OP_JZ_REG   = 5'd17,
		OP_NONE     = 5'd18
	} op_t;

	typedef struct packed {
		logic [OP_BITS-1:0]   op;
		logic [IDX_BITS-1:0]  tgt;
		logic [IDX_BITS-1:0]  src0;
		logic [IDX_BITS-1:0]  src1;
		logic [NIB_BITS-1:0]  nib;
		logic [DATA_BITS-1:0] fw;
		logic [DATA_BITS-1:0] pc;
	} instr_t;

	typedef struct packed {
		logic                en;
		logic [IDX_BITS-1:0] addr_a;
		logic [IDX_BITS-1:0] addr_b;
	} rd_req_t;

	typedef struct packed {
		logic                 en;
		logic [IDX_BITS-1:0]  idx;
		logic [DATA_BITS-1:0] val;
	} wr_req_t;

	typedef struct packed {
		logic                 we;
		logic [IDX_BITS-1:0]  idx;
		logic [DATA_BITS-1:0] val;
		logic                 jump;
		logic [DATA_BITS-1:0] npc;
	} result_t;

endpackage

FILE: design/cpu_exu_regfile.sv
module cpu_exu_regfile #(
	parameter int REG_COUNT = cpu_exu_pkg::REG_COUNT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  cpu_exu_pkg::rd_req_t             rd,
	input  cpu_exu_pkg::wr_req_t             wr,
	output logic [cpu_exu_pkg::DATA_BITS-1:0] val_a,
	output logic [cpu_exu_pkg::DATA_BITS-1:0] val_b
);
	import cpu_exu_pkg::*;

	localparam int IDX_W = $clog2(REG_COUNT);
	localparam logic [IDX_BITS:0] REG_LIM = (IDX_BITS+1)'(REG_COUNT);

	logic [DATA_BITS-1:0] mem [REG_COUNT];
	logic [REG_COUNT-1:0] vld_q;

	logic [DATA_BITS-1:0] rdata_a_s1, rdata_b_s1;
	logic [IDX_BITS-1:0]  addr_a_s1, addr_b_s1;
	logic                 ok_a_s1, ok_b_s1;

	logic                 fwd_v_q;
	logic [IDX_BITS-1:0]  fwd_idx_q;
	logic [DATA_BITS-1:0] fwd_val_q;

	always_ff @(posedge clk) begin
		if (wr.en) begin
			mem[wr.idx[IDX_W-1:0]] <= wr.val;
		end
		if (rd.en) begin
			rdata_a_s1 <= mem[rd.addr_a[IDX_W-1:0]];
			rdata_b_s1 <= mem[rd.addr_b[IDX_W-1:0]];
			addr_a_s1  <= rd.addr_a;
			addr_b_s1  <= rd.addr_b;
			ok_a_s1    <= ({1'b0, rd.addr_a} < REG_LIM) && vld_q[rd.addr_a[IDX_W-1:0]];
			ok_b_s1    <= ({1'b0, rd.addr_b} < REG_LIM) && vld_q[rd.addr_b[IDX_W-1:0]];
		end
		if (wr.en) begin
			fwd_idx_q <= wr.idx;
			fwd_val_q <= wr.val;
		end
	end

	// entries not yet written read as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			fwd_v_q <= 1'b0;
		end else if (wr.en) begin
			vld_q[wr.idx[IDX_W-1:0]] <= 1'b1;
			fwd_v_q                  <= 1'b1;
		end
	end

	// last write bypasses a read taken in the same cycle
	always_comb begin
		if (fwd_v_q && fwd_idx_q == addr_a_s1) begin
			val_a = fwd_val_q;
		end else if (ok_a_s1) begin
			val_a = rdata_a_s1;
		end else begin
			val_a = '0;
		end
		if (fwd_v_q && fwd_idx_q == addr_b_s1) begin
			val_b = fwd_val_q;
		end else if (ok_b_s1) begin
			val_b = rdata_b_s1;
		end else begin
			val_b = '0;
		end
	end

	a_wr_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |-> ({1'b0, wr.idx} < REG_LIM))
		else $error("register write beyond register count");

	a_fwd_tracks_write: assert property (@(posedge clk) disable iff (!arst_n)
		wr.en |=> fwd_v_q && fwd_idx_q == $past(wr.idx) && fwd_val_q == $past(wr.val))
		else $error("bypass register missed a write");

endmodule

FILE: design/cpu_exu_alu.sv
module cpu_exu_alu #(
	parameter int REG_COUNT = cpu_exu_pkg::REG_COUNT_DEF
) (
	input  cpu_exu_pkg::instr_t               ins,
	input  logic [cpu_exu_pkg::DATA_BITS-1:0] val_a,
	input  logic [cpu_exu_pkg::DATA_BITS-1:0] val_b,
	output cpu_exu_pkg::result_t              res
);
	import cpu_exu_pkg::*;

	localparam logic [IDX_BITS:0] REG_LIM = (IDX_BITS+1)'(REG_COUNT);

	logic [9:0]           raw10;
	logic [15:0]          raw16;
	logic [21:0]          raw22;
	logic [DATA_BITS-1:0] imm10, imm16, imm22;
	logic                 wr;
	logic [DATA_BITS-1:0] wval;
	logic                 jmp;
	logic [DATA_BITS-1:0] npc;

	assign raw10 = {ins.src1, ins.nib};
	assign raw16 = {ins.src0, raw10};
	assign raw22 = {ins.tgt, raw16};
	assign imm10 = {{(DATA_BITS-10){raw10[9]}}, raw10};
	assign imm16 = {{(DATA_BITS-16){raw16[15]}}, raw16};
	assign imm22 = {{(DATA_BITS-22){raw22[21]}}, raw22};

	// port a: src0, or tgt for register and conditional jumps; port b: src1, or src0 for conditional register jumps
	always_comb begin
		wr   = 1'b0;
		wval = '0;
		jmp  = 1'b0;
		npc  = ins.pc;
		unique case (op_t'(ins.op))
			OP_LD8_IMM, OP_LD16_IMM: begin
				wr   = 1'b1;
				wval = imm16;
			end
			OP_LD8_FW, OP_LD16_FW, OP_LD32: begin
				wr   = 1'b1;
				wval = ins.fw;
			end
			OP_MOVE: begin
				wr   = 1'b1;
				wval = (ins.src0 == PC_ALIAS) ? ins.pc : val_a;
			end
			OP_ADD_IMM: begin
				wr   = 1'b1;
				wval = val_a + imm10;
			end
			OP_ADD_REG: begin
				wr   = 1'b1;
				wval = val_a + val_b;
			end
			OP_SUB_IMM: begin
				wr   = 1'b1;
				wval = val_a - imm10;
			end
			OP_SUB_REG: begin
				wr   = 1'b1;
				wval = val_a - val_b;
			end
			OP_EQ_IMM: begin
				wr   = 1'b1;
				wval = {{(DATA_BITS-1){1'b0}}, val_a == imm10};
			end
			OP_EQ_REG: begin
				wr   = 1'b1;
				wval = {{(DATA_BITS-1){1'b0}}, val_a == val_b};
			end
			OP_JMP_IMM: begin
				jmp = 1'b1;
				npc = imm22;
			end
			OP_JMP_REG: begin
				jmp = 1'b1;
				npc = val_a;
			end
			OP_JNZ_IMM: begin
				jmp = (val_a != '0);
				npc = jmp ? imm16 : ins.pc;
			end
			OP_JNZ_REG: begin
				jmp = (val_a != '0);
				npc = jmp ? val_b : ins.pc;
			end
			OP_JZ_IMM: begin
				jmp = (val_a == '0);
				npc = jmp ? imm16 : ins.pc;
			end
			OP_JZ_REG: begin
				jmp = (val_a == '0);
				npc = jmp ? val_b : ins.pc;
			end
			default: begin
				wr = 1'b0;
			end
		endcase
	end

	always_comb begin
		res.we   = wr && ({1'b0, ins.tgt} < REG_LIM);
		res.idx  = wr ? ins.tgt : '0;
		res.val  = wr ? wval : '0;
		res.jump = jmp;
		res.npc  = npc;
	end

endmodule

FILE: design/cpu_execute_unit.sv
// cpu_execute_unit: executes one decoded instruction per item against a
// register file of REG_COUNT 32-bit registers (reads of an index at or
// above REG_COUNT give zero, writes there are dropped).
// s_* channel: one instruction per item (operation, target, two sources,
// low nibble, fetched word, current pc). m_* channel: one result per item
// (write enable, index and value, jump taken, next pc).
// Pipeline: an accepted item is registered with both register-port reads;
// the ALU works on it, and the edge that advances it writes the register
// file and the result register, which presents the result on m_*.
// Throughput: one item per cycle while m_tready is high; the two-read,
// one-write register file plus a one-entry write bypass lets dependent
// items follow back to back.
// Reset: registers read as zero until first written (one valid flop per
// register), pipeline empties, no clearing pass is needed.
// Stall: while m_tready is low the result holds, the stage behind it keeps
// one more item, and s_tready drops only when both are full.
module cpu_execute_unit #(
	parameter int REG_COUNT = cpu_exu_pkg::REG_COUNT_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// operation, target_index, first_source, second_source, low_nibble,
	// fetched_word, current_pc, zero fill
	input  logic [cpu_exu_pkg::IN_TDATA_W-1:0]  s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// write_enable, write_index, write_value, jump_taken, next_pc
	output logic [cpu_exu_pkg::OUT_TDATA_W-1:0] m_tdata
);
	import cpu_exu_pkg::*;

	localparam logic [IDX_BITS:0] REG_LIM = (IDX_BITS+1)'(REG_COUNT);

	instr_t               ins_in, ins_s1;
	logic                 v_s1;
	logic                 v_out_q;
	result_t              res, res_q;
	rd_req_t              rd;
	wr_req_t              wr;
	logic [DATA_BITS-1:0] val_a, val_b;
	logic                 accept, out_free, adv;

	assign ins_in.op   = s_tdata[4:0];
	assign ins_in.tgt  = s_tdata[10:5];
	assign ins_in.src0 = s_tdata[16:11];
	assign ins_in.src1 = s_tdata[22:17];
	assign ins_in.nib  = s_tdata[26:23];
	assign ins_in.fw   = s_tdata[58:27];
	assign ins_in.pc   = s_tdata[90:59];

	assign out_free = !v_out_q || m_tready;
	assign adv      = v_s1 && out_free;
	assign s_tready = !v_s1 || out_free;
	assign accept   = s_tvalid && s_tready;

	always_comb begin
		rd.en     = accept;
		rd.addr_a = ins_in.src0;
		rd.addr_b = ins_in.src1;
		case (op_t'(ins_in.op))
			OP_JMP_REG, OP_JNZ_IMM, OP_JZ_IMM: begin
				rd.addr_a = ins_in.tgt;
			end
			OP_JNZ_REG, OP_JZ_REG: begin
				rd.addr_a = ins_in.tgt;
				rd.addr_b = ins_in.src0;
			end
			default: begin
				rd.addr_a = ins_in.src0;
			end
		endcase
	end

	always_comb begin
		wr.en  = adv && res.we;
		wr.idx = res.idx;
		wr.val = res.val;
	end

	cpu_exu_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk   (clk),
		.arst_n(arst_n),
		.rd    (rd),
		.wr    (wr),
		.val_a (val_a),
		.val_b (val_b)
	);

	cpu_exu_alu #(
		.REG_COUNT(REG_COUNT)
	) u_alu (
		.ins  (ins_s1),
		.val_a(val_a),
		.val_b(val_b),
		.res  (res)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			ins_s1 <= ins_in;
		end
		if (adv) begin
			res_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_out_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (out_free) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				v_out_q <= v_s1;
			end
		end
	end

	assign m_tvalid = v_out_q;
	assign m_tdata  = {res_q.npc, res_q.jump, res_q.val, res_q.idx, res_q.we};

	a_stall_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> v_s1 && v_out_q && !m_tready)
		else $error("input stalled with free pipeline space");

	a_jump_no_write: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[39] |-> !m_tdata[0] && m_tdata[38:1] == '0)
		else $error("jump item reports a register write");

	a_write_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> ({1'b0, m_tdata[6:1]} < REG_LIM))
		else $error("write enable set for index beyond register count");

	a_retire_fills_out: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> v_out_q && res_q == $past(res))
		else $error("retired item lost from result register");

endmodule

FILE: sim/tb_cpu_execute_unit.sv
module tb_cpu_execute_unit;
	timeunit 1ns;
	timeprecision 1ps;

	import cpu_exu_pkg::*;

	localparam logic [OP_BITS-1:0] OP_UNKNOWN_LO = 5'd19;
	localparam logic [OP_BITS-1:0] OP_UNKNOWN_HI = 5'd31;
	localparam int STALL_LIMIT  = 2000;
	localparam int RANDOM_ITEMS = 400;
	localparam int HOLD_CYCLES  = 64;
	localparam int DRAIN_CYCLES = 8;

	class exec_scoreboard;
		logic [DATA_BITS-1:0] regs [REG_COUNT_DEF];
		result_t pending [$];
		int mismatches;
		int checked;
		int writes;
		int jumps;

		function new();
			foreach (regs[i])
				regs[i] = '0;
			mismatches = 0;
			checked = 0;
			writes = 0;
			jumps = 0;
		endfunction

		function logic [DATA_BITS-1:0] read_reg(logic [IDX_BITS-1:0] idx);
			return (idx < REG_COUNT_DEF) ? regs[idx] : '0;
		endfunction

		// execute one accepted instruction on the shadow register file
		function void note_instr(instr_t ins);
			logic [9:0] raw10;
			logic [15:0] raw16;
			logic [21:0] raw22;
			logic [DATA_BITS-1:0] imm10, imm16, imm22, a, b, c, wval, npc;
			logic wr, jmp;
			result_t r;
			raw10 = {ins.src1, ins.nib};
			raw16 = {ins.src0, raw10};
			raw22 = {ins.tgt, raw16};
			imm10 = {{22{raw10[9]}}, raw10};
			imm16 = {{16{raw16[15]}}, raw16};
			imm22 = {{10{raw22[21]}}, raw22};
			a = read_reg(ins.src0);
			b = read_reg(ins.src1);
			c = read_reg(ins.tgt);
			wr = 1'b0;
			wval = '0;
			jmp = 1'b0;
			npc = ins.pc;
			case (ins.op)
				OP_LD8_IMM, OP_LD16_IMM: begin
					wr = 1'b1;
					wval = imm16;
				end
				OP_LD8_FW, OP_LD16_FW, OP_LD32: begin
					wr = 1'b1;
					wval = ins.fw;
				end
				OP_MOVE: begin
					wr = 1'b1;
					wval = (ins.src0 == PC_ALIAS) ? ins.pc : a;
				end
				OP_ADD_IMM: begin
					wr = 1'b1;
					wval = a + imm10;
				end
				OP_ADD_REG: begin
					wr = 1'b1;
					wval = a + b;
				end
				OP_SUB_IMM: begin
					wr = 1'b1;
					wval = a - imm10;
				end
				OP_SUB_REG: begin
					wr = 1'b1;
					wval = a - b;
				end
				OP_EQ_IMM: begin
					wr = 1'b1;
					wval = (a == imm10) ? 32'd1 : 32'd0;
				end
				OP_EQ_REG: begin
					wr = 1'b1;
					wval = (a == b) ? 32'd1 : 32'd0;
				end
				OP_JMP_IMM: begin
					jmp = 1'b1;
					npc = imm22;
				end
				OP_JMP_REG: begin
					jmp = 1'b1;
					npc = c;
				end
				OP_JNZ_IMM: if (c != 0) begin
					jmp = 1'b1;
					npc = imm16;
				end
				OP_JNZ_REG: if (c != 0) begin
					jmp = 1'b1;
					npc = a;
				end
				OP_JZ_IMM: if (c == 0) begin
					jmp = 1'b1;
					npc = imm16;
				end
				OP_JZ_REG: if (c == 0) begin
					jmp = 1'b1;
					npc = a;
				end
				default: begin
				end
			endcase
			r.we = wr && (ins.tgt < REG_COUNT_DEF);
			if (r.we)
				regs[ins.tgt] = wval;
			r.idx = wr ? ins.tgt : '0;
			r.val = wr ? wval : '0;
			r.jump = jmp;
			r.npc = npc;
			if (r.we)
				writes++;
			if (jmp)
				jumps++;
			pending.push_back(r);
		endfunction

		function void check_result(logic [OUT_TDATA_W-1:0] d);
			result_t got, want;
			got.we = d[0];
			got.idx = d[6:1];
			got.val = d[38:7];
			got.jump = d[39];
			got.npc = d[71:40];
			if (pending.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: we=%0d idx=%0d val=%h jump=%0d npc=%h",
						got.we, got.idx, got.val, got.jump, got.npc);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (got.we !== want.we || got.idx !== want.idx || got.val !== want.val ||
					got.jump !== want.jump || got.npc !== want.npc) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch on result %0d", checked);
					$display("  expected we=%0d idx=%0d val=%h jump=%0d npc=%h",
						want.we, want.idx, want.val, want.jump, want.npc);
					$display("  actual   we=%0d idx=%0d val=%h jump=%0d npc=%h",
						got.we, got.idx, got.val, got.jump, got.npc);
				end
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_TDATA_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;

	exec_scoreboard sb = new();
	int stall_count = 0;
	int sent = 0;
	int ignored = 0;
	bit sender_steady = 1'b0;
	bit held = 1'b0;

	always #4 clk = ~clk;

	cpu_execute_unit u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata)
	);

	function automatic instr_t make_instr(logic [OP_BITS-1:0] op, logic [IDX_BITS-1:0] tgt,
			logic [IDX_BITS-1:0] s0, logic [IDX_BITS-1:0] s1, logic [NIB_BITS-1:0] nib,
			logic [DATA_BITS-1:0] fw, logic [DATA_BITS-1:0] pc);
		instr_t ins;
		ins.op = op;
		ins.tgt = tgt;
		ins.src0 = s0;
		ins.src1 = s1;
		ins.nib = nib;
		ins.fw = fw;
		ins.pc = pc;
		return ins;
	endfunction

	// bias toward a few registers so results feed later instructions
	function automatic logic [IDX_BITS-1:0] pick_idx();
		int r;
		r = $urandom_range(99);
		if (r < 50)
			return IDX_BITS'($urandom_range(7));
		else if (r < 58)
			return PC_ALIAS;
		return IDX_BITS'($urandom_range(63));
	endfunction

	function automatic instr_t random_instr();
		instr_t ins;
		int r;
		logic [DATA_BITS-1:0] v;
		r = $urandom_range(99);
		if (r < 4)
			ins.op = OP_BITS'($urandom_range(OP_UNKNOWN_HI, OP_UNKNOWN_LO));
		else if (r < 8)
			ins.op = OP_NONE;
		else
			ins.op = OP_BITS'($urandom_range(OP_JZ_REG, OP_LD8_IMM));
		ins.tgt = pick_idx();
		ins.src0 = pick_idx();
		ins.src1 = pick_idx();
		ins.nib = NIB_BITS'($urandom_range(15));
		ins.fw = $urandom;
		ins.pc = $urandom;
		if ($urandom_range(9) == 0) begin
			ins.src1 = '0;
			ins.nib = '0;
			ins.fw = '0;
		end
		if (ins.op == OP_EQ_IMM && $urandom_range(1) == 1) begin
			v = sb.read_reg(ins.src0);
			if (&v[31:9] || ~|v[31:9])
				{ins.src1, ins.nib} = v[9:0];
		end
		if (ins.op == OP_EQ_REG && $urandom_range(2) == 0)
			ins.src1 = ins.src0;
		return ins;
	endfunction

	task automatic drive_instr(instr_t ins);
		s_tdata <= {5'b0, ins.pc, ins.fw, ins.nib, ins.src1, ins.src0, ins.tgt, ins.op};
		s_tvalid <= 1'b1;
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_instr(ins);
		sent++;
		if (ins.op > OP_NONE)
			ignored++;
		if (!sender_steady && $urandom_range(99) < 8) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(4, 1))
				@(posedge clk);
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			sb.check_result(m_tdata);
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			stall_count = 0;
		else
			stall_count++;
		if (stall_count >= STALL_LIMIT) begin
			$display("timeout: no item moved for %0d cycles", STALL_LIMIT);
			$display("tb: failure");
			$finish;
		end
	end

	// result side: random backpressure, one long hold-off, one steady stretch
	initial begin
		wait (arst_n);
		forever begin
			@(posedge clk);
			if (!held && sb.checked >= 100) begin
				held = 1'b1;
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES)
					@(posedge clk);
			end else if (sb.checked >= 250 && sb.checked < 330)
				m_tready <= 1'b1;
			else
				m_tready <= ($urandom_range(99) >= 8);
		end
	end

	initial begin
		int valid_items;
		instr_t ins;
		repeat (9)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// loads at the immediate and data extremes
		drive_instr(make_instr(OP_LD32, 1, 0, 0, 0, 32'hffff_ffff, 32'h0));
		drive_instr(make_instr(OP_LD16_IMM, 2, 6'h20, 6'h00, 4'h0, 32'h0, 32'h4));
		drive_instr(make_instr(OP_LD8_IMM, 3, 6'h1f, 6'h3f, 4'hf, 32'hffff_ffff, 32'h8));
		drive_instr(make_instr(OP_LD8_FW, 4, 0, 0, 0, 32'h1234_5678, 32'hc));
		drive_instr(make_instr(OP_LD16_FW, 63, 63, 63, 4'hf, 32'h8000_0001, 32'h10));
		// move reading the pc alias, then a plain register
		drive_instr(make_instr(OP_MOVE, 5, PC_ALIAS, 0, 0, 32'h0, 32'hffff_ffff));
		drive_instr(make_instr(OP_MOVE, 6, 1, 0, 0, 32'h0, 32'h18));
		// arithmetic with most negative and most positive short immediate
		drive_instr(make_instr(OP_ADD_IMM, 7, 1, 6'h20, 4'h0, 32'h0, 32'h1c));
		drive_instr(make_instr(OP_ADD_IMM, 8, 63, 6'h1f, 4'hf, 32'h0, 32'h20));
		drive_instr(make_instr(OP_ADD_REG, 9, 1, 1, 0, 32'h0, 32'h24));
		drive_instr(make_instr(OP_SUB_IMM, 10, 0, 6'h3f, 4'hf, 32'h0, 32'h28));
		drive_instr(make_instr(OP_SUB_REG, 11, 0, 1, 0, 32'h0, 32'h2c));
		// compares, equal and not equal
		drive_instr(make_instr(OP_EQ_IMM, 12, 10, 0, 4'h1, 32'h0, 32'h30));
		drive_instr(make_instr(OP_EQ_IMM, 13, 10, 0, 4'h0, 32'h0, 32'h34));
		drive_instr(make_instr(OP_EQ_REG, 14, 10, 11, 0, 32'h0, 32'h38));
		drive_instr(make_instr(OP_EQ_REG, 15, 1, 2, 0, 32'h0, 32'h3c));
		// jumps: long immediate extremes, register target, both conditions
		drive_instr(make_instr(OP_JMP_IMM, 6'h20, 0, 0, 0, 32'h0, 32'h40));
		drive_instr(make_instr(OP_JMP_IMM, 6'h1f, 63, 63, 4'hf, 32'h0, 32'h44));
		drive_instr(make_instr(OP_JMP_REG, 1, 0, 0, 0, 32'h0, 32'h48));
		drive_instr(make_instr(OP_JNZ_IMM, 0, 6'h2a, 5, 4'h5, 32'h0, 32'h4c));
		drive_instr(make_instr(OP_JNZ_IMM, 1, 6'h2a, 5, 4'h5, 32'h0, 32'h50));
		drive_instr(make_instr(OP_JNZ_REG, 12, 5, 0, 0, 32'h0, 32'h54));
		drive_instr(make_instr(OP_JZ_IMM, 0, 6'h15, 6'h2a, 4'ha, 32'h0, 32'h58));
		drive_instr(make_instr(OP_JZ_REG, 1, 5, 0, 0, 32'h0, 32'h5c));
		drive_instr(make_instr(OP_NONE, 3, 3, 3, 4'h3, 32'hffff_ffff, 32'h60));
		drive_instr(make_instr(OP_UNKNOWN_HI, 63, 63, 63, 4'hf, 32'hffff_ffff, 32'hffff_ffff));
		drive_instr(make_instr(OP_UNKNOWN_LO, 2, 2, 2, 4'h2, 32'h0, 32'h68));

		valid_items = 0;
		while (valid_items < RANDOM_ITEMS) begin
			sender_steady = (valid_items >= 150 && valid_items < 230);
			ins = random_instr();
			drive_instr(ins);
			if (ins.op <= OP_NONE)
				valid_items++;
		end
		s_tvalid <= 1'b0;

		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		$display("tb: %0d instructions sent (%0d with unused opcodes), %0d results checked",
			sent, ignored, sb.checked);
		$display("tb: %0d register writes, %0d jumps taken, %0d mismatches, %0d left over",
			sb.writes, sb.jumps, sb.mismatches, sb.pending.size());
		if (sb.mismatches == 0 && sb.pending.size() == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule

FILE: filelist.f
design/cpu_exu_pkg.sv
design/cpu_exu_regfile.sv
design/cpu_exu_alu.sv
design/cpu_execute_unit.sv
sim/tb_cpu_execute_unit.sv
